@@ hdl/pfa_pkg.sv @@
// Shared constants and codes for the page frame allocator.
package pfa_pkg;

  localparam int FRAME_W      = 5;
  localparam int NUM_FRAMES   = 1 << FRAME_W;
  localparam int CNT_W        = FRAME_W + 1;
  localparam int MODE_W       = 3;
  localparam int PROCESS_BITS = 8;
  localparam int VPAGE_BITS   = 16;
  localparam int TIME_W       = 32;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FORCE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TEST  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TOUCH = 3'd4;

endpackage

@@ hdl/page_frame_allocator_lru.sv @@
// Page frame allocator with lowest-free allocation and LRU forced eviction.
//
// Usage: one request transaction on the input channel (in_valid/in_stall)
// carries a mode, a frame number, an owner and a timestamp. Each request
// produces exactly one result transaction on the output channel
// (out_valid/out_stall).
// Free, test and touch finish in the accept cycle; their result goes from
// the finish state into the output register. Alloc scans the allocation
// bits one frame per cycle and stops at the lowest free frame. Forced
// alloc reads every last-use time through the single read port of the
// timestamp memory, one frame per cycle, then reads the owner memory for
// the victim.
// The block takes one request at a time; in_stall is high from the accept
// until the result has been moved into the output register. A finished
// result waits in the output register while the receiver stalls, and the
// block can accept the next request meanwhile; a second result waits
// inside until the register is taken.
// Reset (rst, synchronous) marks all frames free, forgets all owners and
// reads every last-use time as zero; there is no clearing pass.
module page_frame_allocator_lru (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pfa_pkg::MODE_W-1:0]      mode,
  input  logic [pfa_pkg::FRAME_W-1:0]     frame,
  input  logic [pfa_pkg::PROCESS_BITS-1:0] process_id,
  input  logic [pfa_pkg::VPAGE_BITS-1:0]  virtual_page,
  input  logic [pfa_pkg::TIME_W-1:0]      use_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pfa_pkg::FRAME_W-1:0]     result_frame,
  output logic                            success,
  output logic                            is_allocated,
  output logic                            evicted_valid,
  output logic [pfa_pkg::PROCESS_BITS-1:0] evicted_process,
  output logic [pfa_pkg::VPAGE_BITS-1:0]  evicted_vpage
);
  import pfa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ALLOC  = 3'd1;
  localparam logic [2:0] S_LRU    = 3'd2;
  localparam logic [2:0] S_OWNER  = 3'd3;
  localparam logic [2:0] S_EVICT  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]              state;
  logic [CNT_W-1:0]        cnt;
  logic [NUM_FRAMES-1:0]   alloc_bits;
  logic [NUM_FRAMES-1:0]   recorded;
  logic [NUM_FRAMES-1:0]   lu_written;
  logic [PROCESS_BITS-1:0] proc_r;
  logic [VPAGE_BITS-1:0]   vpage_r;
  logic [TIME_W-1:0]       best;
  logic [FRAME_W-1:0]      victim;

  logic [FRAME_W-1:0]      res_frame;
  logic                    res_success;
  logic                    res_alloc;
  logic                    res_ev_valid;
  logic [PROCESS_BITS-1:0] res_ev_proc;
  logic [VPAGE_BITS-1:0]   res_ev_vpage;

  // Owner store and last-use store, one read port each.
  logic [PROCESS_BITS-1:0] own_proc_mem [NUM_FRAMES];
  logic [VPAGE_BITS-1:0]   own_vpage_mem [NUM_FRAMES];
  logic [TIME_W-1:0]       lu_mem [NUM_FRAMES];
  logic [PROCESS_BITS-1:0] own_proc_q;
  logic [VPAGE_BITS-1:0]   own_vpage_q;
  logic [TIME_W-1:0]       lu_q;
  logic                    lu_ok;

  logic                    in_fire;
  logic                    out_load;
  logic [FRAME_W-1:0]      idx;
  logic                    alloc_found;
  logic                    own_we;
  logic [FRAME_W-1:0]      own_waddr;
  logic                    lu_we;
  logic [TIME_W-1:0]       lu_val;

  assign in_stall    = (state != S_IDLE);
  assign in_fire     = in_valid && !in_stall;
  assign out_load    = (state == S_FINISH) && (!out_valid || !out_stall);
  assign idx         = cnt[FRAME_W-1:0];
  assign alloc_found = (state == S_ALLOC) && !alloc_bits[idx];
  assign lu_we       = in_fire && (mode == MODE_TOUCH);
  // A timestamp never written since reset reads as zero.
  assign lu_val      = lu_ok ? lu_q : '0;

  always_comb begin
    own_we    = 1'b0;
    own_waddr = idx;
    if (alloc_found) begin
      own_we = 1'b1;
    end else if (state == S_EVICT) begin
      own_we    = 1'b1;
      own_waddr = victim;
    end
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      own_proc_mem[own_waddr]  <= proc_r;
      own_vpage_mem[own_waddr] <= vpage_r;
    end
    own_proc_q  <= own_proc_mem[victim];
    own_vpage_q <= own_vpage_mem[victim];
  end

  always_ff @(posedge clk) begin
    if (lu_we) begin
      lu_mem[frame] <= use_time;
    end
    lu_q <= lu_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      alloc_bits <= '0;
      recorded   <= '0;
      lu_written <= '0;
      lu_ok      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      lu_ok <= lu_written[idx];
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            proc_r       <= process_id;
            vpage_r      <= virtual_page;
            cnt          <= '0;
            res_frame    <= '0;
            res_success  <= 1'b1;
            res_alloc    <= 1'b0;
            res_ev_valid <= 1'b0;
            res_ev_proc  <= '0;
            res_ev_vpage <= '0;
            // Every frame number the field can carry is in range.
            case (mode)
              MODE_ALLOC: state <= S_ALLOC;
              MODE_FORCE: state <= S_LRU;
              MODE_FREE: begin
                alloc_bits[frame] <= 1'b0;
                state             <= S_FINISH;
              end
              MODE_TEST: begin
                res_alloc <= alloc_bits[frame];
                state     <= S_FINISH;
              end
              MODE_TOUCH: begin
                lu_written[frame] <= 1'b1;
                state             <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_ALLOC: begin
          if (alloc_found) begin
            alloc_bits[idx] <= 1'b1;
            recorded[idx]   <= 1'b1;
            res_frame       <= idx;
            state           <= S_FINISH;
          end else if (cnt == CNT_W'(NUM_FRAMES - 1)) begin
            res_success <= 1'b0;
            state       <= S_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_LRU: begin
          // The read issued last cycle belongs to frame cnt-1.
          if (cnt == CNT_W'(1)) begin
            best   <= lu_val;
            victim <= '0;
          end else if (cnt != '0 && lu_val < best) begin
            best   <= lu_val;
            victim <= FRAME_W'(cnt - 1'b1);
          end
          if (cnt == CNT_W'(NUM_FRAMES)) begin
            state <= S_OWNER;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_OWNER: begin
          state <= S_EVICT;
        end
        S_EVICT: begin
          res_frame    <= victim;
          res_ev_valid <= recorded[victim];
          if (recorded[victim]) begin
            res_ev_proc  <= own_proc_q;
            res_ev_vpage <= own_vpage_q;
          end
          recorded[victim] <= 1'b1;
          state            <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            out_valid       <= 1'b1;
            result_frame    <= res_frame;
            success         <= res_success;
            is_allocated    <= res_alloc;
            evicted_valid   <= res_ev_valid;
            evicted_process <= res_ev_proc;
            evicted_vpage   <= res_ev_vpage;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_alloc_marks: assert property (@(posedge clk) disable iff (rst)
    alloc_found |=> alloc_bits[$past(idx)] && recorded[$past(idx)])
    else $error("allocated frame not marked");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && out_stall) |=> state == S_FINISH)
    else $error("result left sequencer while output register was full");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LRU || state == S_ALLOC) |-> cnt <= CNT_W'(NUM_FRAMES))
    else $error("scan counter out of range");

  a_evict_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT) |-> $past(state) == S_OWNER)
    else $error("eviction without owner read");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the page frame allocator with LRU eviction.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pfa_pkg::*;

  // Mode codes above MODE_TOUCH are unused and must leave the state alone.
  localparam logic [MODE_W-1:0] MODE_SPARE = MODE_TOUCH + 3'd1;
  localparam int RANDOM_ITEMS = 1100;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum int {PROF_FILL, PROF_DRAIN, PROF_LRU, PROF_MIXED} profile_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [FRAME_W-1:0]      frame;
    logic [PROCESS_BITS-1:0] process_id;
    logic [VPAGE_BITS-1:0]   virtual_page;
    logic [TIME_W-1:0]       use_time;
    logic                    hold;
  } request_t;

  typedef struct packed {
    logic [FRAME_W-1:0]      result_frame;
    logic                    success;
    logic                    is_allocated;
    logic                    evicted_valid;
    logic [PROCESS_BITS-1:0] evicted_process;
    logic [VPAGE_BITS-1:0]   evicted_vpage;
  } reply_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [MODE_W-1:0]       mode = '0;
  logic [FRAME_W-1:0]      frame = '0;
  logic [PROCESS_BITS-1:0] process_id = '0;
  logic [VPAGE_BITS-1:0]   virtual_page = '0;
  logic [TIME_W-1:0]       use_time = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [FRAME_W-1:0]      result_frame;
  logic                    success;
  logic                    is_allocated;
  logic                    evicted_valid;
  logic [PROCESS_BITS-1:0] evicted_process;
  logic [VPAGE_BITS-1:0]   evicted_vpage;

  page_frame_allocator_lru u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .frame           (frame),
    .process_id      (process_id),
    .virtual_page    (virtual_page),
    .use_time        (use_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_frame    (result_frame),
    .success         (success),
    .is_allocated    (is_allocated),
    .evicted_valid   (evicted_valid),
    .evicted_process (evicted_process),
    .evicted_vpage   (evicted_vpage)
  );

  // Shadow copy of the allocator state.
  logic                    frame_busy [NUM_FRAMES];
  logic                    owner_known [NUM_FRAMES];
  logic [PROCESS_BITS-1:0] owner_proc [NUM_FRAMES];
  logic [VPAGE_BITS-1:0]   owner_page [NUM_FRAMES];
  logic [TIME_W-1:0]       frame_stamp [NUM_FRAMES];

  request_t request_queue [$];
  reply_t   pending_replies [$];
  request_t cur_req;
  int       error_count = 0;
  int       cycle_count = 0;
  int       gap_left = 0;
  int       burst_left = 0;
  int       stall_left = 0;
  int       free_left = 0;
  logic [TIME_W-1:0] clock_stamp = '0;

  function automatic reply_t allocator_response(request_t rq);
    reply_t rp;
    int     victim;
    rp = '0;
    rp.success = 1'b1;
    case (rq.mode)
      MODE_ALLOC: begin
        rp.success = 1'b0;
        for (int i = 0; i < NUM_FRAMES && !rp.success; i++) begin
          if (!frame_busy[i]) begin
            frame_busy[i] = 1'b1;
            owner_known[i] = 1'b1;
            owner_proc[i] = rq.process_id;
            owner_page[i] = rq.virtual_page;
            rp.result_frame = FRAME_W'(i);
            rp.success = 1'b1;
          end
        end
      end
      MODE_FORCE: begin
        // Strict less-than keeps the lowest index among equal timestamps.
        victim = 0;
        for (int i = 1; i < NUM_FRAMES; i++) begin
          if (frame_stamp[i] < frame_stamp[victim]) victim = i;
        end
        if (owner_known[victim]) begin
          rp.evicted_valid = 1'b1;
          rp.evicted_process = owner_proc[victim];
          rp.evicted_vpage = owner_page[victim];
        end
        owner_known[victim] = 1'b1;
        owner_proc[victim] = rq.process_id;
        owner_page[victim] = rq.virtual_page;
        rp.result_frame = FRAME_W'(victim);
      end
      MODE_FREE: frame_busy[rq.frame] = 1'b0;
      MODE_TEST: rp.is_allocated = frame_busy[rq.frame];
      MODE_TOUCH: frame_stamp[rq.frame] = rq.use_time;
      default: ;
    endcase
    return rp;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(profile_t profile);
    int unsigned r;
    logic [MODE_W-1:0] m;
    r = $urandom_range(0, 99);
    case (profile)
      PROF_FILL:
        m = (r < 85) ? MODE_ALLOC : (r < 90) ? MODE_FORCE : (r < 95) ? MODE_TEST : MODE_TOUCH;
      PROF_DRAIN:
        m = (r < 70) ? MODE_FREE : (r < 85) ? MODE_TEST : (r < 90) ? MODE_ALLOC : MODE_TOUCH;
      PROF_LRU:
        m = (r < 45) ? MODE_TOUCH : (r < 80) ? MODE_FORCE : (r < 85) ? MODE_ALLOC :
            (r < 95) ? MODE_TEST : MODE_SPARE + MODE_W'($urandom_range(0, 2));
      default:
        m = (r < 20) ? MODE_ALLOC : (r < 40) ? MODE_FORCE : (r < 55) ? MODE_FREE :
            (r < 65) ? MODE_TEST : (r < 95) ? MODE_TOUCH :
            MODE_SPARE + MODE_W'($urandom_range(0, 2));
    endcase
    return m;
  endfunction

  // A rising clock as a real system would see, plus random values, extremes
  // and small values that force timestamp ties.
  function automatic logic [TIME_W-1:0] pick_stamp();
    logic [TIME_W-1:0] t;
    case ($urandom_range(0, 4))
      0: t = TIME_W'($urandom);
      1: t = TIME_W'($urandom_range(0, 15));
      2: t = '1;
      default: begin
        clock_stamp = clock_stamp + TIME_W'($urandom_range(1, 5));
        t = clock_stamp;
      end
    endcase
    return t;
  endfunction

  task automatic add_request(logic [MODE_W-1:0] m, logic [FRAME_W-1:0] f,
                             logic [PROCESS_BITS-1:0] p, logic [VPAGE_BITS-1:0] v,
                             logic [TIME_W-1:0] t, logic hold);
    request_t rq;
    rq.mode = m;
    rq.frame = f;
    rq.process_id = p;
    rq.virtual_page = v;
    rq.use_time = t;
    rq.hold = hold;
    request_queue.push_back(rq);
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  // Sender: bursts of transactions separated by random gaps. A request marked
  // hold is only presented once every outstanding result has been taken.
  always @(posedge clk) begin : sender
    logic next_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pending_replies.push_back(allocator_response(cur_req));
      next_valid = in_valid && in_stall;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() > 0 &&
                     (!request_queue[0].hold || pending_replies.size() == 0)) begin
          cur_req = request_queue.pop_front();
          mode <= cur_req.mode;
          frame <= cur_req.frame;
          process_id <= cur_req.process_id;
          virtual_page <= cur_req.virtual_page;
          use_time <= cur_req.use_time;
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 12);
            case ($urandom_range(0, 7))
              0, 1, 2, 3: gap_left = $urandom_range(1, 3);
              4, 5: gap_left = $urandom_range(4, 12);
              6: gap_left = $urandom_range(20, 60);
              default: gap_left = 0;
            endcase
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: checks each result transaction and stalls on its own pattern.
  always @(posedge clk) begin : receiver
    reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, got frame %0d success %0b",
                   $time, result_frame, success);
          error_count++;
        end else begin
          want = pending_replies.pop_front();
          check_field("result_frame", want.result_frame, result_frame);
          check_field("success", want.success, success);
          check_field("is_allocated", want.is_allocated, is_allocated);
          check_field("evicted_valid", want.evicted_valid, evicted_valid);
          check_field("evicted_process", want.evicted_process, evicted_process);
          check_field("evicted_vpage", want.evicted_vpage, evicted_vpage);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (free_left > 0) begin
          free_left--;
        end else begin
          case ($urandom_range(0, 3))
            0: begin
              stall_left = 0;
              free_left = $urandom_range(50, 200);
            end
            1: begin
              stall_left = $urandom_range(20, 45);
              free_left = $urandom_range(1, 5);
            end
            default: begin
              stall_left = $urandom_range(1, 3);
              free_left = $urandom_range(1, 4);
            end
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL page_frame_allocator_lru");
      $finish;
    end
  end

  initial begin
    int       random_count;
    int       phase_len;
    logic     first_phase;
    logic     hold_phase;
    profile_t profile;
    logic [MODE_W-1:0] m;

    for (int i = 0; i < NUM_FRAMES; i++) begin
      frame_busy[i] = 1'b0;
      owner_known[i] = 1'b0;
      owner_proc[i] = '0;
      owner_page[i] = '0;
      frame_stamp[i] = '0;
    end

    // Empty map, then forced alloc on a frame with no owner and again on it.
    add_request(MODE_TEST, 5'd0, 8'h00, 16'h0000, 32'h0, 1'b0);
    add_request(MODE_FORCE, 5'd0, 8'hFF, 16'hFFFF, 32'h0, 1'b0);
    add_request(MODE_FORCE, 5'd31, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    // Forced alloc left the bit clear, so alloc still finds frame 0 free.
    add_request(MODE_ALLOC, 5'd0, 8'hA5, 16'h5A5A, 32'h0, 1'b0);
    add_request(MODE_ALLOC, 5'd31, 8'h5A, 16'hA5A5, 32'h0, 1'b0);
    add_request(MODE_TEST, 5'd0, 8'h00, 16'h0000, 32'h0, 1'b0);
    add_request(MODE_TEST, 5'd31, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    // Ties on the oldest timestamp go to the lowest frame.
    add_request(MODE_TOUCH, 5'd0, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    add_request(MODE_TOUCH, 5'd1, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    add_request(MODE_TOUCH, 5'd31, 8'h00, 16'h0000, 32'h0, 1'b0);
    add_request(MODE_FORCE, 5'd0, 8'h3C, 16'hC3C3, 32'h0, 1'b0);
    add_request(MODE_TOUCH, 5'd2, 8'h00, 16'h0000, 32'h1, 1'b0);
    add_request(MODE_FORCE, 5'd0, 8'h01, 16'h8000, 32'h0, 1'b0);
    add_request(MODE_FREE, 5'd0, 8'h00, 16'h0000, 32'h0, 1'b0);
    add_request(MODE_ALLOC, 5'd0, 8'h80, 16'h0001, 32'h0, 1'b0);
    add_request(MODE_FREE, 5'd31, 8'h00, 16'h0000, 32'h0, 1'b0);
    add_request(MODE_TEST, 5'd31, 8'h00, 16'h0000, 32'h0, 1'b0);
    add_request(MODE_SPARE, 5'd31, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_request(MODE_SPARE + 3'd1, 5'd3, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_request(MODE_SPARE + 3'd2, 5'd1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_request(MODE_FREE, 5'd1, 8'h00, 16'h0000, 32'h0, 1'b0);
    add_request(MODE_TEST, 5'd1, 8'h00, 16'h0000, 32'h0, 1'b0);

    // Random phases, each biased toward one kind of traffic. The first one
    // fills the map so the allocation failure path is reached early.
    random_count = 0;
    first_phase = 1'b1;
    while (random_count < RANDOM_ITEMS) begin
      profile = first_phase ? PROF_FILL : profile_t'($urandom_range(0, 3));
      phase_len = $urandom_range(20, 60);
      hold_phase = first_phase || ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len; k++) begin
        m = pick_mode(profile);
        add_request(m, FRAME_W'($urandom_range(0, NUM_FRAMES - 1)),
                    PROCESS_BITS'($urandom), VPAGE_BITS'($urandom), pick_stamp(),
                    hold_phase && (k == 0));
        random_count++;
      end
      first_phase = 1'b0;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (request_queue.size() != 0 || in_valid || pending_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("PASS page_frame_allocator_lru");
    end else begin
      $display("FAIL page_frame_allocator_lru");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/pfa_pkg.sv
hdl/page_frame_allocator_lru.sv
test/testbench.sv
